/* rtl/ppid_pkg.sv */
// shared constants, codes and stage payload types for the positional pid controller
package ppid_pkg;

  localparam int DATA_WIDTH = 24;
  localparam int FRAC_BITS  = 16;
  localparam int GAIN_W     = 32;
  localparam int DRIVE_W    = 32;
  localparam int INTEG_W    = 48;
  localparam int KIND_W     = 2;
  localparam int CFG_IDX_W  = 2;

  localparam int ERR_W     = DATA_WIDTH + 1;
  localparam int DELTA_W   = DATA_WIDTH + 2;
  localparam int ILO_W     = INTEG_W / 2;
  localparam int IHI_W     = INTEG_W - ILO_W;
  localparam int P_ERR_W   = ERR_W + GAIN_W;
  localparam int P_DELTA_W = DELTA_W + GAIN_W;
  localparam int P_ILO_W   = ILO_W + 1 + GAIN_W;
  localparam int P_IHI_W   = IHI_W + GAIN_W;
  localparam int ACC_W     = INTEG_W + GAIN_W + 2;
  localparam int SH_W      = ACC_W - FRAC_BITS;

  typedef enum logic [KIND_W-1:0] {
    KIND_SAMPLE    = 2'd0,
    KIND_CLR_INTEG = 2'd1,
    KIND_CLR_ALL   = 2'd2
  } kind_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_KP = 2'd0,
    CFG_KI = 2'd1,
    CFG_KD = 2'd2
  } cfg_idx_t;

  typedef struct packed {
    logic signed [GAIN_W-1:0] kp;
    logic signed [GAIN_W-1:0] ki;
    logic signed [GAIN_W-1:0] kd;
  } gains_t;

  typedef struct packed {
    logic signed [ERR_W-1:0]   err;
    logic signed [INTEG_W-1:0] integ;
    logic signed [DELTA_W-1:0] delta;
  } front_t;

  typedef struct packed {
    logic signed [P_ERR_W-1:0]   p_err;
    logic signed [P_ILO_W-1:0]   p_ilo;
    logic signed [P_IHI_W-1:0]   p_ihi;
    logic signed [P_DELTA_W-1:0] p_delta;
  } prod_t;

endpackage

/* rtl/ppid_front.sv */
// error, saturating integral and derivative difference, with the controller state
module ppid_front (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [ppid_pkg::KIND_W-1:0]          kind,
  input  logic signed [ppid_pkg::DATA_WIDTH-1:0] setpoint,
  input  logic signed [ppid_pkg::DATA_WIDTH-1:0] measurement,
  output logic                                 q_valid,
  input  logic                                 q_ready,
  output ppid_pkg::front_t                     q
);

  logic signed [ppid_pkg::INTEG_W-1:0] integral_sum;
  logic signed [ppid_pkg::ERR_W-1:0]   previous_error;
  logic signed [ppid_pkg::INTEG_W-1:0] integral_sum_next;
  logic signed [ppid_pkg::ERR_W-1:0]   previous_error_next;
  logic signed [ppid_pkg::ERR_W-1:0]   err;
  logic signed [ppid_pkg::DELTA_W-1:0] delta;
  logic signed [ppid_pkg::INTEG_W:0]   sum_ext;
  logic                                en;
  logic                                accept;
  logic                                is_sample;

  assign en       = !q_valid || q_ready;
  assign in_stall = !en;
  assign accept   = in_valid && en;

  assign err   = ppid_pkg::ERR_W'(setpoint) - ppid_pkg::ERR_W'(measurement);
  assign delta = ppid_pkg::DELTA_W'(err) - ppid_pkg::DELTA_W'(previous_error);

  // one extra bit catches overflow, then clamp
  assign sum_ext = (ppid_pkg::INTEG_W + 1)'(integral_sum) + (ppid_pkg::INTEG_W + 1)'(err);

  always_comb begin
    integral_sum_next   = integral_sum;
    previous_error_next = previous_error;
    is_sample           = 1'b0;
    case (kind)
      ppid_pkg::KIND_SAMPLE: begin
        is_sample           = 1'b1;
        previous_error_next = err;
        if (sum_ext[ppid_pkg::INTEG_W] != sum_ext[ppid_pkg::INTEG_W-1]) begin
          integral_sum_next = sum_ext[ppid_pkg::INTEG_W] ?
                              {1'b1, {(ppid_pkg::INTEG_W-1){1'b0}}} :
                              {1'b0, {(ppid_pkg::INTEG_W-1){1'b1}}};
        end else begin
          integral_sum_next = sum_ext[ppid_pkg::INTEG_W-1:0];
        end
      end
      ppid_pkg::KIND_CLR_INTEG: begin
        integral_sum_next = '0;
      end
      ppid_pkg::KIND_CLR_ALL: begin
        integral_sum_next   = '0;
        previous_error_next = '0;
      end
      default: begin
        integral_sum_next = integral_sum;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      integral_sum   <= '0;
      previous_error <= '0;
      q_valid        <= 1'b0;
    end else begin
      if (accept) begin
        integral_sum   <= integral_sum_next;
        previous_error <= previous_error_next;
      end
      if (en) begin
        q_valid <= accept && is_sample;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q.err   <= err;
      q.integ <= integral_sum_next;
      q.delta <= delta;
    end
  end

endmodule

/* rtl/ppid_mult.sv */
// gain products, the integral term split into two partial products
module ppid_mult (
  input  logic              clk,
  input  logic              rst,
  input  logic              d_valid,
  output logic              d_ready,
  input  ppid_pkg::front_t  d,
  input  ppid_pkg::gains_t  gains,
  output logic              q_valid,
  input  logic              q_ready,
  output ppid_pkg::prod_t   q
);

  logic                                en;
  logic signed [ppid_pkg::ILO_W:0]     ilo;
  logic signed [ppid_pkg::IHI_W-1:0]   ihi;
  logic signed [ppid_pkg::P_ERR_W-1:0]   p_err;
  logic signed [ppid_pkg::P_ILO_W-1:0]   p_ilo;
  logic signed [ppid_pkg::P_IHI_W-1:0]   p_ihi;
  logic signed [ppid_pkg::P_DELTA_W-1:0] p_delta;

  assign en      = !q_valid || q_ready;
  assign d_ready = en;

  // low half as a non-negative number, high half keeps the sign
  assign ilo = {1'b0, d.integ[ppid_pkg::ILO_W-1:0]};
  assign ihi = d.integ[ppid_pkg::INTEG_W-1:ppid_pkg::ILO_W];

  assign p_err   = d.err * gains.kp;
  assign p_ilo   = ilo * gains.ki;
  assign p_ihi   = ihi * gains.ki;
  assign p_delta = d.delta * gains.kd;

  always_ff @(posedge clk) begin
    if (rst) begin
      q_valid <= 1'b0;
    end else if (en) begin
      q_valid <= d_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q.p_err   <= p_err;
      q.p_ilo   <= p_ilo;
      q.p_ihi   <= p_ihi;
      q.p_delta <= p_delta;
    end
  end

endmodule

/* rtl/ppid_out.sv */
// term sum, fractional shift, output saturation and the result register
module ppid_out (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                d_valid,
  output logic                                d_ready,
  input  ppid_pkg::prod_t                     d,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [ppid_pkg::DRIVE_W-1:0] drive,
  output logic                                saturated
);

  logic signed [ppid_pkg::ACC_W-1:0]   acc;
  logic                                acc_valid;
  logic signed [ppid_pkg::ACC_W-1:0]   acc_next;
  logic signed [ppid_pkg::SH_W-1:0]    sh;
  logic [ppid_pkg::SH_W-ppid_pkg::DRIVE_W:0] top_bits;
  logic                                fits;
  logic signed [ppid_pkg::DRIVE_W-1:0] drive_next;
  logic                                o_en;
  logic                                a_en;

  assign o_en    = !out_valid || !out_stall;
  assign a_en    = !acc_valid || o_en;
  assign d_ready = a_en;

  assign acc_next = ppid_pkg::ACC_W'(d.p_err) + ppid_pkg::ACC_W'(d.p_delta)
                  + ppid_pkg::ACC_W'(d.p_ilo)
                  + (ppid_pkg::ACC_W'(d.p_ihi) <<< ppid_pkg::ILO_W);

  // dropping the fraction bits is an arithmetic shift, floor rounding
  assign sh       = acc[ppid_pkg::ACC_W-1:ppid_pkg::FRAC_BITS];
  assign top_bits = sh[ppid_pkg::SH_W-1:ppid_pkg::DRIVE_W-1];
  assign fits     = (&top_bits) || !(|top_bits);

  always_comb begin
    if (fits) begin
      drive_next = sh[ppid_pkg::DRIVE_W-1:0];
    end else if (sh[ppid_pkg::SH_W-1]) begin
      drive_next = {1'b1, {(ppid_pkg::DRIVE_W-1){1'b0}}};
    end else begin
      drive_next = {1'b0, {(ppid_pkg::DRIVE_W-1){1'b1}}};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (a_en) begin
        acc_valid <= d_valid;
      end
      if (o_en) begin
        out_valid <= acc_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (a_en) begin
      acc <= acc_next;
    end
    if (o_en) begin
      drive     <= drive_next;
      saturated <= !fits;
    end
  end

endmodule

/* rtl/positional_pid_controller.sv */
// positional pid controller top level: gain registers and the four-stage datapath
//
// usage
//   input channel (in_valid / in_stall) carries kind, setpoint, measurement.
//   a sample transaction (kind 0) yields one drive / saturated result on the
//   output channel (out_valid / out_stall); clear transactions (kind 1 clears
//   the integral, kind 2 also clears the previous error) and kind 3 give no
//   result. gains are written through cfg_valid / cfg_ready, cfg_index,
//   cfg_data (0 kp, 1 ki*dt, 2 kd/dt, all signed q16.16); cfg_ready is always
//   high, and gains may only change while no sample is in flight.
// timing
//   one transaction per cycle sustained while out_stall stays low. a sample passes
//   through front (error, integral), gain products, term sum, and shift and
//   clamp before it shows up on out_valid. the integral update closes its loop
//   within the front stage, which is what holds the rate at one item per clock.
// reset and stall
//   rst (synchronous) clears gains, integral, previous error and all valids.
//   a stalled result holds on the output; upstream stages keep filling any
//   empty slots, and in_stall rises only once every stage is occupied.
module positional_pid_controller (
  input  logic                                    clk,
  input  logic                                    rst,
  // input channel
  input  logic                                    in_valid,
  output logic                                    in_stall,
  input  logic [ppid_pkg::KIND_W-1:0]             kind,
  input  logic signed [ppid_pkg::DATA_WIDTH-1:0]  setpoint,
  input  logic signed [ppid_pkg::DATA_WIDTH-1:0]  measurement,
  // output channel
  output logic                                    out_valid,
  input  logic                                    out_stall,
  output logic signed [ppid_pkg::DRIVE_W-1:0]     drive,
  output logic                                    saturated,
  // gain register writes
  input  logic                                    cfg_valid,
  output logic                                    cfg_ready,
  input  logic [ppid_pkg::CFG_IDX_W-1:0]          cfg_index,
  input  logic [ppid_pkg::GAIN_W-1:0]             cfg_data
);

  ppid_pkg::gains_t gains;
  ppid_pkg::front_t front_q;
  ppid_pkg::prod_t  prod_q;
  logic             front_valid;
  logic             mult_ready;
  logic             mult_valid;
  logic             out_ready;

  // gain registers; the user writes them only while idle, the block does not enforce it
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      gains <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        ppid_pkg::CFG_KP: gains.kp <= cfg_data;
        ppid_pkg::CFG_KI: gains.ki <= cfg_data;
        ppid_pkg::CFG_KD: gains.kd <= cfg_data;
        default: gains <= gains;
      endcase
    end
  end

  // error, integral and derivative difference; owns the controller state
  ppid_front u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .kind        (kind),
    .setpoint    (setpoint),
    .measurement (measurement),
    .q_valid     (front_valid),
    .q_ready     (mult_ready),
    .q           (front_q)
  );

  // the four gain products
  ppid_mult u_mult (
    .clk     (clk),
    .rst     (rst),
    .d_valid (front_valid),
    .d_ready (mult_ready),
    .d       (front_q),
    .gains   (gains),
    .q_valid (mult_valid),
    .q_ready (out_ready),
    .q       (prod_q)
  );

  // sum, shift, clamp, result register
  ppid_out u_out (
    .clk       (clk),
    .rst       (rst),
    .d_valid   (mult_valid),
    .d_ready   (out_ready),
    .d         (prod_q),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .drive     (drive),
    .saturated (saturated)
  );

`ifndef SYNTHESIS
  // a clipped result sits at one of the two range limits
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && saturated) |->
      (drive == {1'b0, {(ppid_pkg::DRIVE_W-1){1'b1}}}) ||
      (drive == {1'b1, {(ppid_pkg::DRIVE_W-1){1'b0}}}))
    else $error("saturated result not at a range limit");

  // clear and unused transactions never enter the datapath
  assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall && (kind != ppid_pkg::KIND_SAMPLE)) |=> !front_valid)
    else $error("non-sample transaction produced a datapath item");

  // a front item blocked by the product stage is held unchanged
  assert property (@(posedge clk) disable iff (rst)
    (front_valid && !mult_ready) |=> (front_valid && $stable(front_q)))
    else $error("blocked front stage item lost or changed");
`endif

endmodule

/* test/positional_pid_controller_tb.sv */
// self-checking testbench for the positional pid controller: random and directed samples
`timescale 1ns / 1ps

module positional_pid_controller_tb;

  // run shape
  localparam int RANDOM_PER_PHASE = 80;
  localparam int PHASES           = 6;
  localparam int SETTLE_CYCLES    = 12;   // pipeline is four deep, leave some margin
  localparam int HOLD_CYCLES      = 80;   // long receiver hold-off, well past pipeline depth
  localparam int WATCHDOG_LIMIT   = 3000; // cycles with no transaction of any kind
  localparam int REPORT_LIMIT     = 10;

  localparam int DW = ppid_pkg::DATA_WIDTH;
  localparam int GW = ppid_pkg::GAIN_W;

  // codes the package leaves unnamed
  localparam logic [ppid_pkg::KIND_W-1:0]    KIND_UNUSED = 2'd3;
  localparam logic [ppid_pkg::CFG_IDX_W-1:0] CFG_UNUSED  = 2'd3;

  // operand and gain extremes
  localparam logic signed [DW-1:0] VAL_MAX  = {1'b0, {(DW-1){1'b1}}};
  localparam logic signed [DW-1:0] VAL_MIN  = {1'b1, {(DW-1){1'b0}}};
  localparam logic [GW-1:0]        GAIN_MAX = {1'b0, {(GW-1){1'b1}}};
  localparam logic [GW-1:0]        GAIN_MIN = {1'b1, {(GW-1){1'b0}}};
  localparam logic [GW-1:0]        GAIN_ONE = GW'(1) << ppid_pkg::FRAC_BITS;

  // clamp bounds of the drive, held at the width of the exact sum
  localparam logic signed [127:0] DRIVE_HI = 128'sh7FFF_FFFF;
  localparam logic signed [127:0] DRIVE_LO = -128'sh8000_0000;

  typedef struct packed {
    logic [ppid_pkg::KIND_W-1:0] kind;
    logic signed [DW-1:0]        sp;
    logic signed [DW-1:0]        ms;
  } pid_item_t;

  typedef struct packed {
    logic signed [ppid_pkg::DRIVE_W-1:0] drive;
    logic                                saturated;
  } drive_result_t;

  // clock and reset
  logic clk = 1'b0;
  logic rst = 1'b1;

  // block ports, the driven ones all known from time zero
  logic                                in_valid    = 1'b0;
  logic                                in_stall;
  logic [ppid_pkg::KIND_W-1:0]         kind        = ppid_pkg::KIND_SAMPLE;
  logic signed [DW-1:0]                setpoint    = '0;
  logic signed [DW-1:0]                measurement = '0;
  logic                                out_valid;
  logic                                out_stall   = 1'b0;
  logic signed [ppid_pkg::DRIVE_W-1:0] drive;
  logic                                saturated;
  logic                                cfg_valid   = 1'b0;
  logic                                cfg_ready;
  logic [ppid_pkg::CFG_IDX_W-1:0]      cfg_index   = ppid_pkg::CFG_KP;
  logic [GW-1:0]                       cfg_data    = '0;

  // stimulus and expectation stores
  pid_item_t     samples_pending[$];
  drive_result_t drives_due[$];

  // controller state as the testbench tracks it
  logic signed [GW-1:0]                kp_q, ki_q, kd_q;
  logic signed [ppid_pkg::INTEG_W-1:0] integ_q;
  logic signed [ppid_pkg::ERR_W-1:0]   prev_err_q;

  // idling knobs, set per phase by the sequencer
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned holds_requested = 0;
  int unsigned holds_served = 0;
  int          hold_left = 0;

  // bookkeeping
  bit in_took = 1'b0;
  int quiet_cycles = 0;
  int fail_count = 0;
  int reports = 0;

  positional_pid_controller dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .kind        (kind),
    .setpoint    (setpoint),
    .measurement (measurement),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .drive       (drive),
    .saturated   (saturated),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // advance the tracked controller by one accepted item; a sample yields a drive
  task automatic track_controller(input logic [ppid_pkg::KIND_W-1:0] k,
                                  input logic signed [DW-1:0] sp,
                                  input logic signed [DW-1:0] ms,
                                  output bit has_result, output drive_result_t res);
    logic signed [ppid_pkg::ERR_W-1:0] err;
    logic signed [ppid_pkg::ERR_W:0]   delta;
    logic signed [ppid_pkg::INTEG_W:0] sum;
    logic signed [127:0]               acc, e_w, i_w, d_w, kp_w, ki_w, kd_w;
    has_result = 1'b0;
    res = '0;
    case (k)
      ppid_pkg::KIND_CLR_INTEG: integ_q = '0;
      ppid_pkg::KIND_CLR_ALL: begin
        integ_q    = '0;
        prev_err_q = '0;
      end
      ppid_pkg::KIND_SAMPLE: begin
        err   = sp - ms;
        delta = err - prev_err_q;
        // integral saturates rather than wrapping
        sum = integ_q + err;
        if (sum[ppid_pkg::INTEG_W] != sum[ppid_pkg::INTEG_W-1])
          integ_q = sum[ppid_pkg::INTEG_W] ? {1'b1, {(ppid_pkg::INTEG_W-1){1'b0}}} :
                                             {1'b0, {(ppid_pkg::INTEG_W-1){1'b1}}};
        else
          integ_q = sum[ppid_pkg::INTEG_W-1:0];
        // exact sum of the three terms, then the arithmetic shift to integer
        e_w  = err;
        i_w  = integ_q;
        d_w  = delta;
        kp_w = kp_q;
        ki_w = ki_q;
        kd_w = kd_q;
        acc  = e_w * kp_w + i_w * ki_w + d_w * kd_w;
        acc  = acc >>> ppid_pkg::FRAC_BITS;
        prev_err_q = err;
        if (acc > DRIVE_HI) begin
          res.drive     = GAIN_MAX;
          res.saturated = 1'b1;
        end else if (acc < DRIVE_LO) begin
          res.drive     = GAIN_MIN;
          res.saturated = 1'b1;
        end else begin
          res.drive     = acc[ppid_pkg::DRIVE_W-1:0];
          res.saturated = 1'b0;
        end
        has_result = 1'b1;
      end
      default: ; // unused kind leaves every bit of state alone
    endcase
  endtask

  // extreme and near-extreme operand values
  function automatic logic signed [DW-1:0] edge_value();
    case ($urandom_range(4))
      0: edge_value = VAL_MAX;
      1: edge_value = VAL_MIN;
      2: edge_value = '0;
      3: edge_value = '1;
      default: edge_value = VAL_MIN + DW'(1);
    endcase
  endfunction

  // mostly samples of mixed character, a sprinkling of clears and unused kinds
  function automatic pid_item_t random_item();
    pid_item_t it;
    int unsigned pick;
    pick  = $urandom_range(99);
    it.sp = DW'($urandom);
    it.ms = DW'($urandom);
    if (pick < 3) it.kind = ppid_pkg::KIND_CLR_INTEG;
    else if (pick < 6) it.kind = ppid_pkg::KIND_CLR_ALL;
    else if (pick < 9) it.kind = KIND_UNUSED;
    else begin
      it.kind = ppid_pkg::KIND_SAMPLE;
      case ($urandom_range(3))
        0: ; // full range on both operands
        1: begin
          // small values around zero, drive stays in range for modest gains
          it.sp = DW'($urandom_range(4000)) - DW'(2000);
          it.ms = DW'($urandom_range(4000)) - DW'(2000);
        end
        2: begin
          it.sp = edge_value();
          it.ms = edge_value();
        end
        default: begin
          // measurement tracking the setpoint closely
          it.ms = it.sp + DW'($urandom_range(200)) - DW'(100);
        end
      endcase
    end
    return it;
  endfunction

  function automatic pid_item_t make_item(input logic [ppid_pkg::KIND_W-1:0] k,
                                          input logic signed [DW-1:0] sp,
                                          input logic signed [DW-1:0] ms);
    pid_item_t it;
    it.kind = k;
    it.sp   = sp;
    it.ms   = ms;
    return it;
  endfunction

  // append one item to the driver queue
  task automatic add_pending(input pid_item_t it);
    samples_pending.insert(samples_pending.size(), it);
  endtask

  // operand extremes, both clears, the unused kind, and small steps around zero
  task automatic push_directed();
    add_pending(make_item(ppid_pkg::KIND_SAMPLE, '0, '0));
    add_pending(make_item(ppid_pkg::KIND_SAMPLE, VAL_MAX, VAL_MIN));
    add_pending(make_item(ppid_pkg::KIND_SAMPLE, VAL_MIN, VAL_MAX));
    add_pending(make_item(ppid_pkg::KIND_SAMPLE, VAL_MAX, VAL_MAX));
    add_pending(make_item(ppid_pkg::KIND_SAMPLE, VAL_MIN, VAL_MIN));
    add_pending(make_item(ppid_pkg::KIND_CLR_INTEG, VAL_MAX, VAL_MIN));
    add_pending(make_item(ppid_pkg::KIND_SAMPLE, 24'sd100, -24'sd50));
    add_pending(make_item(KIND_UNUSED, VAL_MAX, VAL_MAX));
    add_pending(make_item(ppid_pkg::KIND_SAMPLE, 24'sd1, '0));
    add_pending(make_item(ppid_pkg::KIND_CLR_ALL, '1, '1));
    add_pending(make_item(ppid_pkg::KIND_SAMPLE, '1, '0));
    add_pending(make_item(ppid_pkg::KIND_SAMPLE, VAL_MAX, '0));
    add_pending(make_item(ppid_pkg::KIND_SAMPLE, '0, VAL_MIN));
  endtask

  // one register write transaction, launched at a falling edge
  task automatic write_gain(input logic [ppid_pkg::CFG_IDX_W-1:0] idx,
                            input logic [GW-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic load_gains(input logic [GW-1:0] kp, input logic [GW-1:0] ki,
                            input logic [GW-1:0] kd);
    write_gain(ppid_pkg::CFG_KP, kp);
    write_gain(ppid_pkg::CFG_KI, ki);
    write_gain(ppid_pkg::CFG_KD, kd);
  endtask

  // full-range gain scaled down by a random shift, so both small and large gains show up
  function automatic logic [GW-1:0] random_gain();
    logic signed [GW-1:0] g;
    g = $urandom;
    return g >>> $urandom_range(24);
  endfunction

  // input driver: a held transaction stays put until taken, otherwise maybe idle
  always @(negedge clk) begin : feed_inputs
    pid_item_t nxt;
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_took) begin
      if (samples_pending.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        nxt = samples_pending[0];
        samples_pending.delete(0);
        in_valid    <= 1'b1;
        kind        <= nxt.kind;
        setpoint    <= nxt.sp;
        measurement <= nxt.ms;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // output receiver: random stall, plus a long hold-off whenever the sequencer asks
  always @(negedge clk) begin : pace_outputs
    if (holds_served < holds_requested) begin
      hold_left = HOLD_CYCLES;
      holds_served++;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // monitor: register writes and input transactions feed the tracked state,
  // result transactions are checked against the oldest expected drive
  always @(posedge clk) begin : watch_ports
    drive_result_t want;
    drive_result_t got;
    bit has_result;
    in_took = in_valid && !in_stall;
    if (rst) begin
      kp_q         = '0;
      ki_q         = '0;
      kd_q         = '0;
      integ_q      = '0;
      prev_err_q   = '0;
      quiet_cycles = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          ppid_pkg::CFG_KP: kp_q = cfg_data;
          ppid_pkg::CFG_KI: ki_q = cfg_data;
          ppid_pkg::CFG_KD: kd_q = cfg_data;
          default: ; // unused index writes nothing
        endcase
      end
      if (in_took) begin
        track_controller(kind, setpoint, measurement, has_result, want);
        if (has_result) drives_due.insert(drives_due.size(), want);
      end
      if (out_valid && !out_stall) begin
        got.drive     = drive;
        got.saturated = saturated;
        if (drives_due.size() == 0) begin
          fail_count++;
          if (reports < REPORT_LIMIT) begin
            reports++;
            $display("unexpected result: drive %0d saturated %0b", got.drive, got.saturated);
          end
        end else begin
          want = drives_due[0];
          drives_due.delete(0);
          if (got.drive !== want.drive || got.saturated !== want.saturated) begin
            fail_count++;
            if (reports < REPORT_LIMIT) begin
              reports++;
              $display("drive mismatch: expected %0d sat %0b, got %0d sat %0b",
                       want.drive, want.saturated, got.drive, got.saturated);
            end
          end
        end
      end
      if (in_took || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
  end

  // watchdog: too long without any transaction means a lost or stuck result
  initial begin
    while (quiet_cycles < WATCHDOG_LIMIT) @(posedge clk);
    $display("positional_pid_controller_tb: errors");
    $finish;
  end

  // sequencer: reset once, then phases of gains, items and idling profile
  initial begin
    repeat (7) @(negedge clk);
    rst <= 1'b0;
    for (int ph = 0; ph < PHASES; ph++) begin
      // first the sender idles lightly and the receiver heavily, then the
      // reverse, and the last two phases run with no idling at all
      case (ph / 2)
        0: begin
          send_idle_pct = 6;
          recv_idle_pct = 45;
        end
        1: begin
          send_idle_pct = 45;
          recv_idle_pct = 6;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      // gains change only here, with the pipeline drained
      case (ph)
        0: load_gains(GAIN_ONE, 32'h0000_0100, 32'h0000_8000);
        1: load_gains(GAIN_MAX, GAIN_MIN, GAIN_MIN);
        2: load_gains(random_gain(), random_gain(), random_gain());
        3: begin
          load_gains(GAIN_MIN, GAIN_MAX, GAIN_MAX);
          write_gain(CFG_UNUSED, $urandom);
        end
        4: load_gains(random_gain(), '0, '0);
        default: load_gains(random_gain(), random_gain(), random_gain());
      endcase
      if (ph < 2) push_directed();
      repeat (RANDOM_PER_PHASE) add_pending(random_item());
      // long output hold-off while items keep coming, so the input stalls
      if (ph == 0 || ph == 4) holds_requested++;
      // checked at the rising edge, where the queue and in_valid are settled
      while (samples_pending.size() != 0 || in_valid || drives_due.size() != 0)
        @(posedge clk);
      // settling margin before the gains change for the next phase
      repeat (SETTLE_CYCLES) @(posedge clk);
    end
    if (fail_count == 0 && drives_due.size() == 0)
      $display("positional_pid_controller_tb: clean");
    else
      $display("positional_pid_controller_tb: errors");
    $finish;
  end

endmodule
